// ===== rtl/core/crv_pkg.sv =====
package crv_pkg;

	// Default component width of the packed vectors
	localparam int COMPONENT_WIDTH = 18;
	// Width of one packed input vector
	localparam int FIELD_W = 54;
	// Quotient bits (t and c magnitudes up to 2^56) and their fraction bits
	localparam int QB = 57;
	localparam int QF = 32;
	// Signed width of t and c
	localparam int QW = QB + 1;
	// Split of |t| for the square: high and low parts
	localparam int HW = 29;
	localparam int LW = QB - HW;
	// Discriminant width and its shift for 4*c
	localparam int XW = 2 * QB;
	localparam int C4_SH = QF + 2;
	// Square root bits and compare width
	localparam int SB = 58;
	localparam int VW = 2 * SB;
	// Output curvature width
	localparam int OW = 32;

	localparam logic [QB-1:0] QLIM = {1'b1, {(QB-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SINGULAR = 2'd1,
		ST_NEG_DISC = 2'd2
	} status_t;

	// Overflow marks of the two quotients
	typedef struct packed {
		logic a;
		logic b;
	} div_ovf_t;

	// Shift to 16 fraction bits toward zero, then saturate to 32 bits
	function automatic logic [OW-1:0] to_q16(input logic signed [QW:0] v, input logic half);
		logic [QW:0] m;
		logic [QW:0] sh;
		m = v[QW] ? (QW+1)'(-v) : (QW+1)'(v);
		sh = half ? (m >> 17) : (m >> 16);
		if (!v[QW]) begin
			if (sh > (QW+1)'(32'h7FFF_FFFF))
				return 32'h7FFF_FFFF;
			return OW'(sh);
		end
		if (sh > (QW+1)'(33'h0_8000_0000))
			sh = (QW+1)'(33'h0_8000_0000);
		return OW'((QW+1)'(0) - sh);
	endfunction

endpackage

// ===== rtl/core/crv_div.sv =====
module crv_div #(
	parameter int NW = 4 * crv_pkg::COMPONENT_WIDTH + 7,
	parameter int GW = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [NW-1:0]         d,
	input  logic [NW-1:0]         na,
	input  logic [NW-1:0]         nb,
	input  logic [GW-1:0]         in_tag,
	output logic                  out_valid,
	output logic [crv_pkg::QB-1:0] qa,
	output logic [crv_pkg::QB-1:0] qb,
	output crv_pkg::div_ovf_t     ovf,
	output logic [GW-1:0]         out_tag
);
	import crv_pkg::*;

	localparam int SH = QB - QF;

	logic          vld_s   [0:QB];
	logic [NW-1:0] d_s     [0:QB];
	logic [NW-1:0] rema_s  [0:QB];
	logic [NW-1:0] remb_s  [0:QB];
	logic [QB-1:0] srca_s  [0:QB];
	logic [QB-1:0] srcb_s  [0:QB];
	logic [QB-1:0] quota_s [0:QB];
	logic [QB-1:0] quotb_s [0:QB];
	div_ovf_t      ovf_s   [0:QB];
	logic [GW-1:0] tag_s   [0:QB];

	logic          vld_nx   [0:QB];
	logic [NW-1:0] d_nx     [0:QB];
	logic [NW-1:0] rema_nx  [0:QB];
	logic [NW-1:0] remb_nx  [0:QB];
	logic [QB-1:0] srca_nx  [0:QB];
	logic [QB-1:0] srcb_nx  [0:QB];
	logic [QB-1:0] quota_nx [0:QB];
	logic [QB-1:0] quotb_nx [0:QB];
	div_ovf_t      ovf_nx   [0:QB];
	logic [GW-1:0] tag_nx   [0:QB];

	// Entry: high part of the numerator seeds the remainder, overflow check
	// Stages: one quotient bit each, restoring compare and subtract
	always_comb begin
		logic [NW:0] ca;
		logic [NW:0] cb;
		logic        ga;
		logic        gb;
		vld_nx[0]   = in_valid;
		d_nx[0]     = d;
		rema_nx[0]  = na >> SH;
		remb_nx[0]  = nb >> SH;
		srca_nx[0]  = {na[SH-1:0], {QF{1'b0}}};
		srcb_nx[0]  = {nb[SH-1:0], {QF{1'b0}}};
		quota_nx[0] = '0;
		quotb_nx[0] = '0;
		ovf_nx[0].a = (na >> SH) >= d;
		ovf_nx[0].b = (nb >> SH) >= d;
		tag_nx[0]   = in_tag;
		for (int k = 1; k <= QB; k++) begin
			ca = {rema_s[k-1], srca_s[k-1][QB-1]};
			cb = {remb_s[k-1], srcb_s[k-1][QB-1]};
			ga = ca >= {1'b0, d_s[k-1]};
			gb = cb >= {1'b0, d_s[k-1]};
			rema_nx[k]  = ga ? NW'(ca - {1'b0, d_s[k-1]}) : NW'(ca);
			remb_nx[k]  = gb ? NW'(cb - {1'b0, d_s[k-1]}) : NW'(cb);
			srca_nx[k]  = srca_s[k-1] << 1;
			srcb_nx[k]  = srcb_s[k-1] << 1;
			quota_nx[k] = {quota_s[k-1][QB-2:0], ga};
			quotb_nx[k] = {quotb_s[k-1][QB-2:0], gb};
			vld_nx[k]   = vld_s[k-1];
			d_nx[k]     = d_s[k-1];
			ovf_nx[k]   = ovf_s[k-1];
			tag_nx[k]   = tag_s[k-1];
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k <= QB; k++)
				vld_s[k] <= vld_nx[k];
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k <= QB; k++) begin
				d_s[k]     <= d_nx[k];
				rema_s[k]  <= rema_nx[k];
				remb_s[k]  <= remb_nx[k];
				srca_s[k]  <= srca_nx[k];
				srcb_s[k]  <= srcb_nx[k];
				quota_s[k] <= quota_nx[k];
				quotb_s[k] <= quotb_nx[k];
				ovf_s[k]   <= ovf_nx[k];
				tag_s[k]   <= tag_nx[k];
			end
		end
	end

	assign out_valid = vld_s[QB];
	assign qa        = quota_s[QB];
	assign qb        = quotb_s[QB];
	assign ovf       = ovf_s[QB];
	assign out_tag   = tag_s[QB];

endmodule

// ===== rtl/core/crv_sqrt.sv =====
module crv_sqrt #(
	parameter int GW = 2 * crv_pkg::QW + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [crv_pkg::XW-1:0] disc,
	input  logic [GW-1:0]          in_tag,
	output logic                   out_valid,
	output logic [crv_pkg::SB-1:0] root,
	output logic [GW-1:0]          out_tag
);
	import crv_pkg::*;

	logic          vld_s [0:SB-1];
	logic [XW-1:0] rem_s [0:SB-1];
	logic [SB-1:0] rt_s  [0:SB-1];
	logic [GW-1:0] tag_s [0:SB-1];

	logic          vld_in [0:SB-1];
	logic [XW-1:0] rem_in [0:SB-1];
	logic [SB-1:0] rt_in  [0:SB-1];
	logic [GW-1:0] tag_in [0:SB-1];
	logic [XW-1:0] rem_nx [0:SB-1];
	logic [SB-1:0] rt_nx  [0:SB-1];

	// Stage inputs: ports for the first stage, previous register otherwise
	always_comb begin
		vld_in[0] = in_valid;
		rem_in[0] = disc;
		rt_in[0]  = '0;
		tag_in[0] = in_tag;
		for (int k = 1; k < SB; k++) begin
			vld_in[k] = vld_s[k-1];
			rem_in[k] = rem_s[k-1];
			rt_in[k]  = rt_s[k-1];
			tag_in[k] = tag_s[k-1];
		end
	end

	// One root bit per stage, high bit first: test rem >= 2*s*2^b + 2^2b
	always_comb begin
		logic [VW-1:0] trial;
		logic          take;
		for (int k = 0; k < SB; k++) begin
			trial = (VW'(rt_in[k]) << (SB - k)) | (VW'(1) << (2 * (SB - 1 - k)));
			take  = VW'(rem_in[k]) >= trial;
			rem_nx[k] = take ? XW'(VW'(rem_in[k]) - trial) : rem_in[k];
			rt_nx[k]  = take ? (rt_in[k] | (SB'(1) << (SB - 1 - k))) : rt_in[k];
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SB; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < SB; k++)
				vld_s[k] <= vld_in[k];
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SB; k++) begin
				rem_s[k] <= rem_nx[k];
				rt_s[k]  <= rt_nx[k];
				tag_s[k] <= tag_in[k];
			end
		end
	end

	assign out_valid = vld_s[SB-1];
	assign root      = rt_s[SB-1];
	assign out_tag   = tag_s[SB-1];

endmodule

// ===== rtl/core/surface_curvature_from_derivatives_top.sv =====
// Principal curvatures from the first and second fundamental forms.
// Input channel (in_valid/in_ready): normal and six derivative vectors, each
// three signed Q6.12 components packed x low, z high. Output channel
// (out_valid/out_ready): Gaussian, mean, maximum and minimum curvature in
// signed Q16.16, saturated, plus a status code (valid, singular metric,
// negative discriminant; curvatures are zero unless valid).
// An input transfer reaches out_valid through 5 stages of dot products and
// form products, 58 stages of the pipelined divider (an entry stage, then
// one quotient bit per stage), 4 stages for the discriminant, 58 stages of
// the pipelined square root (one root bit per stage) and the output register.
// Throughput is one item per cycle while the receiver does not stall. Reset
// empties the pipeline and the output register; no clearing pass is needed.
// When the receiver stalls, the result is held in the output register and
// the pipeline keeps moving while its last stage is empty; once the last
// stage holds an item behind the held result, the whole pipeline freezes
// and in_ready drops, so nothing is lost or repeated.
module surface_curvature_from_derivatives_top #(
	parameter int COMPONENT_WIDTH = crv_pkg::COMPONENT_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [crv_pkg::FIELD_W-1:0]    normal_vec,
	input  logic [crv_pkg::FIELD_W-1:0]    du_vec,
	input  logic [crv_pkg::FIELD_W-1:0]    dv_vec,
	input  logic [crv_pkg::FIELD_W-1:0]    duu_vec,
	input  logic [crv_pkg::FIELD_W-1:0]    dvv_vec,
	input  logic [crv_pkg::FIELD_W-1:0]    duv_vec,
	input  logic [crv_pkg::FIELD_W-1:0]    dvu_vec,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [crv_pkg::OW-1:0]  gauss_curv,
	output logic signed [crv_pkg::OW-1:0]  mean_curv,
	output logic signed [crv_pkg::OW-1:0]  max_curv,
	output logic signed [crv_pkg::OW-1:0]  min_curv,
	output logic [1:0]                     status
);
	import crv_pkg::*;

	localparam int CW   = COMPONENT_WIDTH;
	localparam int PW   = 3 * CW;
	localparam int DW   = 2 * CW + 2;
	localparam int H    = DW / 2;
	localparam int LPW  = H + 1 + DW;
	localparam int HPW  = 2 * DW - H;
	localparam int PRW  = 2 * DW;
	localparam int NW   = 2 * DW + 3;
	localparam int NP   = 8;
	localparam int DGW  = 3;
	localparam int SGW  = 2 * QW + 2;

	// Product slots
	localparam int P_EG    = 0;
	localparam int P_FF    = 1;
	localparam int P_L00G  = 2;
	localparam int P_L01F  = 3;
	localparam int P_L10F  = 4;
	localparam int P_L11E  = 5;
	localparam int P_L0011 = 6;
	localparam int P_L0110 = 7;

	function automatic logic signed [DW-1:0] dot3(input logic [PW-1:0] a, input logic [PW-1:0] b);
		logic signed [DW-1:0]   acc;
		logic signed [2*CW-1:0] p;
		acc = '0;
		for (int k = 0; k < 3; k++) begin
			p   = $signed(a[k*CW +: CW]) * $signed(b[k*CW +: CW]);
			acc = acc + DW'(p);
		end
		return acc;
	endfunction

	logic adv;
	logic v_last;

	// ---------------- stage 1: dot products
	logic [PW-1:0] nrm, xu, xv, xuu, xvv, xuv, xvu;
	logic                 v_s1;
	logic signed [DW-1:0] e_s1, f_s1, g_s1, l00_s1, l11_s1, l01_s1, l10_s1;

	assign nrm = PW'(normal_vec);
	assign xu  = PW'(du_vec);
	assign xv  = PW'(dv_vec);
	assign xuu = PW'(duu_vec);
	assign xvv = PW'(dvv_vec);
	assign xuv = PW'(duv_vec);
	assign xvu = PW'(dvu_vec);

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1   <= dot3(xu, xu);
			f_s1   <= dot3(xu, xv);
			g_s1   <= dot3(xv, xv);
			l00_s1 <= dot3(xuu, nrm);
			l11_s1 <= dot3(xvv, nrm);
			l01_s1 <= dot3(xuv, nrm);
			l10_s1 <= dot3(xvu, nrm);
		end
	end

	// ---------------- stage 2: partial products, first operand split
	logic signed [DW-1:0]  opa [0:NP-1];
	logic signed [DW-1:0]  opb [0:NP-1];
	logic                  v_s2;
	logic signed [LPW-1:0] plo_s2 [0:NP-1];
	logic signed [HPW-1:0] phi_s2 [0:NP-1];

	always_comb begin
		opa[P_EG]    = e_s1;   opb[P_EG]    = g_s1;
		opa[P_FF]    = f_s1;   opb[P_FF]    = f_s1;
		opa[P_L00G]  = l00_s1; opb[P_L00G]  = g_s1;
		opa[P_L01F]  = l01_s1; opb[P_L01F]  = f_s1;
		opa[P_L10F]  = l10_s1; opb[P_L10F]  = f_s1;
		opa[P_L11E]  = l11_s1; opb[P_L11E]  = e_s1;
		opa[P_L0011] = l00_s1; opb[P_L0011] = l11_s1;
		opa[P_L0110] = l01_s1; opb[P_L0110] = l10_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NP; i++) begin
				plo_s2[i] <= $signed({1'b0, opa[i][H-1:0]}) * opb[i];
				phi_s2[i] <= $signed(opa[i][DW-1:H]) * opb[i];
			end
		end
	end

	// ---------------- stage 3: recombine products
	logic                  v_s3;
	logic signed [PRW-1:0] prod_s3 [0:NP-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NP; i++)
				prod_s3[i] <= ($signed(PRW'(phi_s2[i])) <<< H) + PRW'(plo_s2[i]);
		end
	end

	// ---------------- stage 4: determinant and numerators
	logic                 v_s4;
	logic signed [NW-1:0] det_s4, nt_s4, nc_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s4 <= NW'(prod_s3[P_EG]) - NW'(prod_s3[P_FF]);
			nt_s4  <= NW'(prod_s3[P_L00G]) - NW'(prod_s3[P_L01F])
				- NW'(prod_s3[P_L10F]) + NW'(prod_s3[P_L11E]);
			nc_s4  <= NW'(prod_s3[P_L0011]) - NW'(prod_s3[P_L0110]);
		end
	end

	// ---------------- stage 5: magnitudes and singular check
	logic          v_s5;
	logic [NW-1:0] det_s5, ntm_s5, ncm_s5;
	logic          sing_s5, ntn_s5, ncn_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s5  <= $unsigned(det_s4);
			sing_s5 <= det_s4 <= 0;
			ntn_s5  <= nt_s4[NW-1];
			ncn_s5  <= nc_s4[NW-1];
			ntm_s5  <= nt_s4[NW-1] ? $unsigned(-nt_s4) : $unsigned(nt_s4);
			ncm_s5  <= nc_s4[NW-1] ? $unsigned(-nc_s4) : $unsigned(nc_s4);
		end
	end

	// ---------------- divider: t and c quotients with 32 fraction bits
	logic           dv_valid;
	logic [QB-1:0]  qt, qc;
	div_ovf_t       dv_ovf;
	logic [DGW-1:0] dv_tag;

	crv_div #(
		.NW (NW),
		.GW (DGW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s5),
		.d         (det_s5),
		.na        (ntm_s5),
		.nb        (ncm_s5),
		.in_tag    ({sing_s5, ntn_s5, ncn_s5}),
		.out_valid (dv_valid),
		.qa        (qt),
		.qb        (qc),
		.ovf       (dv_ovf),
		.out_tag   (dv_tag)
	);

	// ---------------- stage 6: saturate and sign
	logic [QB-1:0]        qts, qcs;
	logic                 v_s6, sing_s6;
	logic signed [QW-1:0] t_s6, c_s6;

	assign qts = (dv_ovf.a || qt > QLIM) ? QLIM : qt;
	assign qcs = (dv_ovf.b || qc > QLIM) ? QLIM : qc;

	always_ff @(posedge clk) begin
		if (adv) begin
			sing_s6 <= dv_tag[2];
			t_s6    <= dv_tag[1] ? -$signed({1'b0, qts}) : $signed({1'b0, qts});
			c_s6    <= dv_tag[0] ? -$signed({1'b0, qcs}) : $signed({1'b0, qcs});
		end
	end

	// ---------------- stage 7: partial products of t squared
	logic [QB-1:0]        tm6;
	logic                 v_s7, sing_s7;
	logic signed [QW-1:0] t_s7, c_s7;
	logic [2*HW-1:0]      hh_s7;
	logic [HW+LW-1:0]     hl_s7;
	logic [2*LW-1:0]      ll_s7;

	assign tm6 = t_s6[QW-1] ? QB'(-t_s6) : QB'(t_s6);

	always_ff @(posedge clk) begin
		if (adv) begin
			sing_s7 <= sing_s6;
			t_s7    <= t_s6;
			c_s7    <= c_s6;
			hh_s7   <= tm6[QB-1:LW] * tm6[QB-1:LW];
			hl_s7   <= tm6[QB-1:LW] * tm6[LW-1:0];
			ll_s7   <= tm6[LW-1:0] * tm6[LW-1:0];
		end
	end

	// ---------------- stage 8: t squared and 4c, both at 64 fraction bits
	logic [QB-1:0]        cm7;
	logic                 v_s8, sing_s8, cpos_s8;
	logic signed [QW-1:0] t_s8, c_s8;
	logic [XW-1:0]        tsq_s8, c4_s8;

	assign cm7 = c_s7[QW-1] ? QB'(-c_s7) : QB'(c_s7);

	always_ff @(posedge clk) begin
		if (adv) begin
			sing_s8 <= sing_s7;
			t_s8    <= t_s7;
			c_s8    <= c_s7;
			cpos_s8 <= !c_s7[QW-1] && (c_s7 != '0);
			tsq_s8  <= (XW'(hh_s7) << (2 * LW)) + (XW'(hl_s7) << (LW + 1)) + XW'(ll_s7);
			c4_s8   <= XW'(cm7) << C4_SH;
		end
	end

	// ---------------- stage 9: discriminant and status
	logic                 v_s9;
	logic [XW-1:0]        disc_s9;
	logic signed [QW-1:0] t_s9, c_s9;
	status_t              st_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s9    <= t_s8;
			c_s9    <= c_s8;
			disc_s9 <= cpos_s8 ? (tsq_s8 - c4_s8) : (tsq_s8 + c4_s8);
			if (sing_s8)
				st_s9 <= ST_SINGULAR;
			else if (cpos_s8 && (tsq_s8 < c4_s8))
				st_s9 <= ST_NEG_DISC;
			else
				st_s9 <= ST_OK;
		end
	end

	// ---------------- square root of the discriminant
	logic                 sq_valid;
	logic [SB-1:0]        sq_root;
	logic [SGW-1:0]       sq_tag;
	logic signed [QW-1:0] t_f, c_f;
	status_t              st_f;

	crv_sqrt #(
		.GW (SGW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s9),
		.disc      (disc_s9),
		.in_tag    ({t_s9, c_s9, st_s9}),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_tag   (sq_tag)
	);

	assign t_f    = $signed(sq_tag[SGW-1 -: QW]);
	assign c_f    = $signed(sq_tag[QW+1 -: QW]);
	assign st_f   = status_t'(sq_tag[1:0]);
	assign v_last = sq_valid;

	// ---------------- output register
	logic signed [QW:0] tx, sx;
	logic               out_valid_q;
	logic [OW-1:0]      gauss_q, mean_q, max_q, min_q;
	status_t            status_q;

	assign tx = (QW+1)'(t_f);
	assign sx = $signed({1'b0, QW'(sq_root)});

	// Move the pipeline while its last stage is empty or the output frees
	assign adv      = !v_last || !out_valid_q || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk) begin
		if (adv && v_last) begin
			status_q <= st_f;
			if (st_f == ST_OK) begin
				gauss_q <= to_q16((QW+1)'(c_f), 1'b0);
				mean_q  <= to_q16(tx, 1'b1);
				max_q   <= to_q16(tx + sx, 1'b1);
				min_q   <= to_q16(tx - sx, 1'b1);
			end else begin
				gauss_q <= '0;
				mean_q  <= '0;
				max_q   <= '0;
				min_q   <= '0;
			end
		end
	end

	// Advance valid bits of stages 1 to 9 and the output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				v_s1 <= in_valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
				v_s6 <= dv_valid;
				v_s7 <= v_s6;
				v_s8 <= v_s7;
				v_s9 <= v_s8;
			end
			if (adv && v_last)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign gauss_curv = $signed(gauss_q);
	assign mean_curv  = $signed(mean_q);
	assign max_curv   = $signed(max_q);
	assign min_curv   = $signed(min_q);
	assign status     = status_q;

endmodule

// ===== rtl/core/crv_chk.sv =====
module crv_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [crv_pkg::OW-1:0] gauss_curv,
	input logic signed [crv_pkg::OW-1:0] mean_curv,
	input logic signed [crv_pkg::OW-1:0] max_curv,
	input logic signed [crv_pkg::OW-1:0] min_curv,
	input logic [1:0]                    status
);
	import crv_pkg::*;

	// Hold stalled max and min curvature and status unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(max_curv)
			&& $stable(min_curv) && $stable(status))
		else $error("stalled result changed");

	// Zero all curvatures on a singular metric or negative discriminant
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_SINGULAR || status == ST_NEG_DISC) |->
			gauss_curv == '0 && mean_curv == '0 && max_curv == '0 && min_curv == '0)
		else $error("curvature not zero on error status");

	// Keep the principal curvatures ordered
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> max_curv >= min_curv)
		else $error("max curvature below min curvature");

	// Keep the mean between the principal curvatures
	a_mean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> mean_curv <= max_curv && mean_curv >= min_curv)
		else $error("mean curvature outside principal range");

endmodule

bind surface_curvature_from_derivatives_top crv_chk u_crv_chk (.*);
